FILE: src/nps_pkg.sv
// ============================================================================
// nps_pkg: shared types and constants for the note pitch shift block
// Request codes, table geometry, log2 precision and the queue entry format.
// ============================================================================
package nps_pkg;

    localparam int MAX_NOTES     = 64;
    localparam int LOG_FRAC_BITS = 16;
    localparam int IDX_W         = $clog2(MAX_NOTES);
    localparam int CNT_W         = $clog2(MAX_NOTES + 1);
    localparam int FCNT_W        = $clog2(LOG_FRAC_BITS + 1);

    // Request queue between the front end and the back end (power of two).
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [24:0] SHIFT_MAX = 25'sh0FFFFFF;
    localparam logic signed [24:0] SHIFT_MIN = -25'sh1000000;
    // log2(440) is 8.7813597..., the fraction truncated to 24 bits is 0xC80730
    // (0xC807 at 16 bits, the same value the squaring iteration produces).
    localparam logic [4:0]  A4_LOG_INT    = 5'd8;
    localparam logic [23:0] A4_LOG_FRAC24 = 24'hC80730;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Classified work handed from the front end to the back end.
    typedef struct packed {
        req_t               req;
        logic signed [15:0] subdivision;
        logic [6:0]         note_num;
        logic signed [15:0] fine_tune;
        logic [31:0]        source_freq;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_LOG,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } back_state_t;

endpackage

FILE: src/nps_front.sv
// ============================================================================
// nps_front: input acceptance and request queue
// Accepts transactions, classifies the request and buffers them in a FIFO.
// ============================================================================
module nps_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nps_pkg::work_t in_work,
    output logic           q_valid,
    input  logic           q_ready,
    output nps_pkg::work_t q_work
);
    import nps_pkg::*;

    work_t              fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;
    work_t              cls;

    // Unused request codes are normalized to REQ_NONE.
    always_comb
    begin
        cls = in_work;
        if (in_work.req != REQ_CLEAR && in_work.req != REQ_APPEND &&
            in_work.req != REQ_QUERY)
        begin
            cls.req = REQ_NONE;
        end
    end

    assign in_ready = (fill_reg != QFILL_W'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_work   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_valid && q_ready)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            fill_reg <= fill_reg + QFILL_W'(in_valid && in_ready)
                                 - QFILL_W'(q_valid && q_ready);
        end
    end

endmodule

FILE: src/nps_back.sv
// ============================================================================
// nps_back: note table and pitch shift engine
// Holds the note table, scans it for a query and computes the shift in 1/256 cents.
// ============================================================================
module nps_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  nps_pkg::work_t     q_work,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [24:0] res_shift,
    output logic               res_found,
    output logic               res_full
);
    import nps_pkg::*;

    back_state_t state_reg, state_next;

    logic [38:0]        mem [MAX_NOTES];
    logic [38:0]        rd_data_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic               scan_rd_reg;
    logic               have_reg;
    logic signed [15:0] best_sub_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    work_t              work_reg;

    logic [63:0]        m_reg;
    logic [FCNT_W-1:0]  step_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [LOG_FRAC_BITS-1:0] a4_frac;
    logic [4:0]         p_reg;
    logic signed [31:0] d_reg;
    logic [50:0]        mag_reg;
    logic               found_reg, full_reg, out_valid_reg;
    logic [6:0]         midi_reg;
    logic signed [15:0] fine_reg;

    logic [4:0]  msb_pos;
    logic [63:0] sq;
    logic        take;
    logic        scan_end;
    logic signed [15:0] rd_sub;

    // log2(440): fraction from the same truncated iteration, held as a constant.
    assign a4_frac = LOG_FRAC_BITS'(A4_LOG_FRAC24 >> (24 - LOG_FRAC_BITS));

    always_comb
    begin
        msb_pos = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (work_reg.source_freq[i])
            begin
                msb_pos = 5'(i);
            end
        end
    end

    assign sq       = (m_reg[31:0] * m_reg[31:0]) >> 31;
    assign rd_sub   = rd_data_reg[38:23];
    assign scan_end = (scan_reg == count_reg);
    assign take     = scan_rd_reg && (rd_sub <= work_reg.subdivision) &&
                      (!have_reg || rd_sub > best_sub_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_work.req == REQ_QUERY) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!scan_rd_reg)
                begin
                    state_next = (have_reg && work_reg.source_freq != 32'd0) ?
                                 ST_LOG : ST_DONE;
                end
            end
            ST_LOG:
            begin
                if (step_reg == FCNT_W'(LOG_FRAC_BITS))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready = (state_reg == ST_IDLE);
    end

    // Table writes and reads; one read per scan cycle, data registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_work.req == REQ_APPEND &&
            count_reg != CNT_W'(MAX_NOTES))
        begin
            mem[count_reg[IDX_W-1:0]] <= {q_work.subdivision, q_work.note_num,
                                          q_work.fine_tune};
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= mem[scan_reg[IDX_W-1:0]];
        end
        else if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[best_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                work_reg <= q_work;
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    best_sub_reg <= rd_sub;
                    best_idx_reg <= IDX_W'(scan_reg - CNT_W'(1));
                end
            end
            ST_READ:
            begin
                if (take)
                begin
                    best_sub_reg <= rd_sub;
                    best_idx_reg <= IDX_W'(scan_reg - CNT_W'(1));
                end
                m_reg    <= 64'({32'd0, work_reg.source_freq} << (5'd31 - msb_pos));
                p_reg    <= msb_pos;
                frac_reg <= '0;
            end
            ST_LOG:
            begin
                if (step_reg == FCNT_W'(0))
                begin
                    midi_reg <= rd_data_reg[22:16];
                    fine_reg <= rd_data_reg[15:0];
                end
                if (step_reg != FCNT_W'(LOG_FRAC_BITS))
                begin
                    if (sq >= 64'h1_0000_0000)
                    begin
                        m_reg    <= sq >> 1;
                        frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        m_reg    <= sq;
                        frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], 1'b0};
                    end
                end
                else
                begin
                    d_reg <= $signed({27'd0, A4_LOG_INT} - {27'd0, p_reg} + 32'd16)
                             * (32'sd1 <<< LOG_FRAC_BITS)
                             + $signed(32'(a4_frac)) - $signed(32'(frac_reg));
                end
            end
            ST_MUL:
            begin
                mag_reg <= 51'((d_reg < 0 ? -d_reg : d_reg)) * 51'd307200;
            end
            default:
            begin
            end
        endcase
    end

    logic signed [52:0] total;
    logic [50:0]        rnd;
    always_comb
    begin
        rnd   = (mag_reg + (51'd1 << (LOG_FRAC_BITS - 1))) >> LOG_FRAC_BITS;
        total = (d_reg < 0 ? -$signed({2'b0, rnd}) : $signed({2'b0, rnd}))
              + 53'($signed({1'b0, midi_reg}) - 9'sd69) * 53'sd25600
              + 53'(fine_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            scan_rd_reg   <= 1'b0;
            have_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            res_shift     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_reg    <= '0;
                    scan_rd_reg <= 1'b0;
                    have_reg    <= 1'b0;
                    step_reg    <= '0;
                    found_reg   <= 1'b0;
                    full_reg    <= 1'b0;
                    res_shift   <= '0;
                    if (q_valid)
                    begin
                        if (q_work.req != REQ_QUERY)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        if (q_work.req == REQ_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                        else if (q_work.req == REQ_APPEND)
                        begin
                            if (count_reg != CNT_W'(MAX_NOTES))
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                full_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (take)
                    begin
                        have_reg <= 1'b1;
                    end
                    scan_rd_reg <= !scan_end;
                    if (!scan_end)
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end
                ST_READ:
                begin
                    if (take)
                    begin
                        have_reg <= 1'b1;
                    end
                    scan_rd_reg <= 1'b0;
                    if (!scan_rd_reg)
                    begin
                        found_reg <= have_reg;
                        if (!(have_reg && work_reg.source_freq != 32'd0))
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_LOG:
                begin
                    step_reg <= step_reg + FCNT_W'(1);
                end
                ST_SUM:
                begin
                    if (total > 53'(SHIFT_MAX))
                    begin
                        res_shift <= SHIFT_MAX;
                    end
                    else if (total < 53'(SHIFT_MIN))
                    begin
                        res_shift <= SHIFT_MIN;
                    end
                    else
                    begin
                        res_shift <= 25'(total);
                    end
                    out_valid_reg <= 1'b1;
                end
                ST_DONE:
                begin
                    // The result is held here until the receiver takes it.
                    if (res_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_valid = out_valid_reg;
    assign res_found = found_reg;
    assign res_full  = full_reg;

endmodule

FILE: src/note_pitch_shift_cents.sv
// ============================================================================
// note_pitch_shift_cents: note table pitch shift unit
// Keeps a table of notes and answers pitch shift queries in 1/256 cents.
// ============================================================================
// channel  direction  tdata fields (low to high)             tuser
// s_axis   in         subdivision, note_num, fine_tune,      req_type
//                     source_freq (71 bits in 72)
// m_axis   out        shift_cents (25 bits in 32)            note_found, table_full
//
// The engine answers a clear, an append or an unused request without a scan.
// A query scans every stored note, one memory read a cycle, then runs 16
// serial squaring steps for log2; it skips those steps when no note is found
// or the frequency is zero. Reset empties the table at once. A waiting
// result holds the engine; the 4-entry input queue keeps accepting meanwhile
// until it is full.
// ============================================================================
module note_pitch_shift_cents (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // subdivision, note_num, fine_tune, source_freq
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // shift_cents
    output logic [1:0]  m_axis_tuser   // note_found, table_full
);
    import nps_pkg::*;

    work_t              in_work, q_work;
    logic               q_valid, q_ready;
    logic signed [24:0] shift;
    logic               found, full;

    always_comb
    begin
        in_work.req         = req_t'(s_axis_tuser);
        in_work.subdivision = s_axis_tdata[15:0];
        in_work.note_num    = s_axis_tdata[22:16];
        in_work.fine_tune   = s_axis_tdata[38:23];
        in_work.source_freq = s_axis_tdata[70:39];
    end

    nps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_work  (in_work),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_work   (q_work)
    );

    nps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_work    (q_work),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_shift (shift),
        .res_found (found),
        .res_full  (full)
    );

    assign m_axis_tdata = {7'd0, shift};
    assign m_axis_tuser = {full, found};

    // A result never claims both a found note and a dropped append.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("found and full both set");

    // A nonzero shift only comes with a found note.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[24:0] != 25'd0) |-> m_axis_tuser[0])
        else $error("shift without note");

endmodule

FILE: tb/sv/tb_note_pitch_shift_cents.sv
// ============================================================================
// tb_note_pitch_shift_cents: stream-level test of the note pitch shift unit
// Drives clear, append, query and unused requests with random bursts and
// receiver stalls, predicts every result and compares each field in order.
// ============================================================================
module tb_note_pitch_shift_cents;
    import nps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [24:0] shift;
        logic               found;
        logic               full;
    } pitch_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Predictor copy of the note table.
    logic signed [15:0] note_sub  [MAX_NOTES];
    logic [6:0]         note_midi [MAX_NOTES];
    logic signed [15:0] note_fine [MAX_NOTES];
    int                 note_total;

    pitch_result_t pending_results[$];
    int            error_count;
    int            idle_cycles;
    int            burst_left;
    bit            stall_mode;

    note_pitch_shift_cents DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Truncated log2 of a nonzero Q16.16 value, LOG_FRAC_BITS fraction bits.
    function automatic longint log2_q16(logic [31:0] x);
        int          msb;
        logic [63:0] mant;
        longint      frac;
        msb  = 31;
        frac = 0;
        while (msb > 0 && x[msb] == 1'b0)
            msb--;
        mant = 64'(x) << (31 - msb);
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return longint'(msb - 16) * (longint'(1) << LOG_FRAC_BITS) + frac;
    endfunction

    function automatic logic signed [24:0] cents_shift(logic [31:0] freq, logic [6:0] midi,
                                                       logic signed [15:0] fine);
        longint   diff;
        bit       neg;
        longint   mag;
        longint   total;
        diff = log2_q16(32'd440 << 16) - log2_q16(freq);
        neg  = diff < 0;
        mag  = (neg ? -diff : diff) * 307200;
        mag  = (mag + (longint'(1) << (LOG_FRAC_BITS - 1))) >>> LOG_FRAC_BITS;
        total = neg ? -mag : mag;
        total += (longint'(midi) - 69) * 25600 + longint'(fine);
        if (total > 16777215)
            total = 16777215;
        if (total < -16777216)
            total = -16777216;
        return total[24:0];
    endfunction

    function automatic pitch_result_t predict_pitch(req_t req, logic signed [15:0] sub,
                                                    logic [6:0] midi, logic signed [15:0] fine,
                                                    logic [31:0] freq);
        pitch_result_t res;
        int            best;
        res  = '0;
        best = -1;
        case (req)
            REQ_CLEAR: note_total = 0;
            REQ_APPEND:
            begin
                if (note_total < MAX_NOTES)
                begin
                    note_sub[note_total]  = sub;
                    note_midi[note_total] = midi;
                    note_fine[note_total] = fine;
                    note_total++;
                end
                else
                    res.full = 1'b1;
            end
            REQ_QUERY:
            begin
                for (int i = 0; i < note_total; i++)
                    if (note_sub[i] <= sub && (best < 0 || note_sub[i] > note_sub[best]))
                        best = i;
                if (best >= 0)
                begin
                    res.found = 1'b1;
                    if (freq != 0)
                        res.shift = cents_shift(freq, note_midi[best], note_fine[best]);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Sends one transaction; the sender works in bursts that are sometimes separated by gaps.
    task automatic send_request(req_t req, logic signed [15:0] sub, logic [6:0] midi,
                                logic signed [15:0] fine, logic [31:0] freq);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, freq, fine, midi, sub};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_pitch(req, sub, midi, fine, freq));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("result with nothing expected");
                    error_count++;
                end
                else
                begin
                    pitch_result_t want;
                    want = pending_results.pop_front();
                    if (m_axis_tdata[24:0] !== want.shift)
                        report_mismatch("shift_cents", longint'($signed(m_axis_tdata[24:0])),
                                        longint'(want.shift));
                    if (m_axis_tuser[0] !== want.found)
                        report_mismatch("note_found", longint'(m_axis_tuser[0]),
                                        longint'(want.found));
                    if (m_axis_tuser[1] !== want.full)
                        report_mismatch("table_full", longint'(m_axis_tuser[1]),
                                        longint'(want.full));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if ($urandom_range(0, 199) == 0)
                stall_mode <= ~stall_mode;
            m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles > 5000)
        begin
            $display("tb_note_pitch_shift_cents: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] random_freq();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(1, 32'h00FF_FFFF);
            2: return 32'h01B8_0000 + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom_range(0, 3) << $urandom_range(0, 30);
        endcase
    endfunction

    task automatic test_directed();
        send_request(REQ_QUERY, 16'sd0, 7'd0, 16'sd0, 32'h01B8_0000);   // empty table
        send_request(REQ_APPEND, 16'sh8000, 7'd0, -16'sd25600, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 16'sd100, 7'd127, 16'sd25599, 32'd0);
        send_request(REQ_APPEND, 16'sd100, 7'd69, 16'sd0, 32'd0);      // tie, earlier wins
        send_request(REQ_APPEND, 16'sd32767, 7'd60, 16'sd128, 32'd0);
        send_request(REQ_QUERY, 16'sh8000, 7'd127, 16'sd0, 32'h01B8_0000);
        send_request(REQ_QUERY, 16'sd100, 7'd0, 16'sd0, 32'h01B8_0000);
        send_request(REQ_QUERY, 16'sd200, 7'd0, 16'sd0, 32'd1);
        send_request(REQ_QUERY, 16'sd200, 7'd0, 16'sd0, 32'hFFFF_FFFF);
        send_request(REQ_QUERY, 16'sd32767, 7'd0, 16'sd0, 32'd0);      // zero frequency
        send_request(REQ_QUERY, 16'sd32767, 7'd0, 16'sd0, 32'h0001_0000);
        send_request(REQ_NONE, 16'sd1, 7'd1, 16'sd1, 32'd1);
        send_request(REQ_CLEAR, 16'sd0, 7'd0, 16'sd0, 32'd0);
        send_request(REQ_QUERY, 16'sd32767, 7'd0, 16'sd0, 32'h01B8_0000);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < MAX_NOTES + 3; i++)
            send_request(REQ_APPEND, 16'($urandom()), 7'($urandom()), 16'($urandom()),
                         $urandom());
        for (int i = 0; i < 6; i++)
            send_request(REQ_QUERY, 16'($urandom()), 7'($urandom()), 16'($urandom()),
                         random_freq());
        wait_drained();
        send_request(REQ_CLEAR, 16'($urandom()), 7'($urandom()), 16'($urandom()),
                     $urandom());
    endtask

    task automatic test_random_sessions();
        int sent;
        int n;
        sent = 0;
        while (sent < 1100)
        begin
            // A session: a clear, a few appends, then queries mixed with noise.
            send_request(REQ_CLEAR, 16'($urandom()), 7'($urandom()), 16'($urandom()),
                         $urandom());
            n = $urandom_range(0, 10) == 0 ? $urandom_range(50, 70) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                send_request(REQ_APPEND, 16'($urandom_range(0, 1) ? $urandom() :
                             $urandom_range(0, 40) - 20), 7'($urandom()),
                             16'($urandom_range(0, 51199) - 25600), $urandom());
            for (int i = 0; i < 15; i++)
            begin
                case ($urandom_range(0, 9))
                    0: send_request(REQ_NONE, 16'($urandom()), 7'($urandom()),
                                    16'($urandom()), $urandom());
                    1: send_request(REQ_APPEND, 16'($urandom()), 7'($urandom()),
                                    16'($urandom()), $urandom());
                    default: send_request(REQ_QUERY, 16'($urandom_range(0, 1) ? $urandom() :
                                          $urandom_range(0, 40) - 20), 7'($urandom()),
                                          16'($urandom()),
                                          $urandom_range(0, 9) == 0 ? 32'd0 : random_freq());
                endcase
            end
            sent += n + 16;
        end
    endtask

    initial
    begin
        error_count   = 0;
        note_total    = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        stall_mode    = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_CLEAR;
        m_axis_tready = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random_sessions();
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_note_pitch_shift_cents: done, clean");
        else
            $display("tb_note_pitch_shift_cents: done, errors");
        $finish;
    end
endmodule
